// File: hdl/skm_pkg.sv
// ----------------------------------------------------------------------------
// skm_pkg
// Shared types and constants for the stream keyword masker.
// ----------------------------------------------------------------------------
package skm_pkg;

  localparam int unsigned MAX_KEY_LEN = 8;
  localparam int unsigned KEY_W       = 8 * MAX_KEY_LEN;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_KEY_LEN);

  localparam logic [7:0] STAR_CHAR = 8'h2A;

  // register byte addresses
  localparam logic [3:0] ADDR_KEY_BYTES  = 4'h0;
  localparam logic [3:0] ADDR_KEY_LENGTH = 4'h8;

  typedef struct packed {
    logic       end_of_input;
    logic [7:0] data_byte;
  } item_t;

  // clamp the programmed length into 1..MAX_KEY_LEN
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = LEN_W'(1);
    end else if (raw > LEN_W'(MAX_KEY_LEN)) begin
      res = LEN_W'(MAX_KEY_LEN);
    end
    return res;
  endfunction

endpackage

// File: hdl/stream_keyword_masker_core.sv
// ----------------------------------------------------------------------------
// stream_keyword_masker_core
// Copies a byte stream, masking every occurrence of a programmed key with '*'.
// Path: an accepted item passes the input queue, the scan window, the pending result and the output register.
// Throughput: one result per cycle while the sink does not stall; per item
// the scanner adds a load step and a closing step, and a flush state when
// end of text stops at a partial match; items are not overlapped in the scanner.
// Reset: asynchronous, clears held bytes and queues; key 0, key length 1.
// ----------------------------------------------------------------------------
module stream_keyword_masker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
  input  logic                      s_axis_tlast,   // end_of_input
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
  output logic                      m_axis_tlast,   // last_of_run
  output logic                      m_axis_tuser,   // end_of_text
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  logic [skm_pkg::KEY_W-1:0] key_bytes_q;
  logic [skm_pkg::LEN_W-1:0] key_length_q;
  logic                      wr_en;
  skm_pkg::item_t            in_item, q_item;
  logic                      q_valid, q_ready;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q  <= '0;
      key_length_q <= skm_pkg::LEN_W'(1);
    end else if (wr_en) begin
      unique case (paddr)
        skm_pkg::ADDR_KEY_BYTES:  key_bytes_q  <= pwdata;
        skm_pkg::ADDR_KEY_LENGTH: key_length_q <= pwdata[skm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      skm_pkg::ADDR_KEY_BYTES:  prdata = key_bytes_q;
      skm_pkg::ADDR_KEY_LENGTH: prdata = {{(64 - skm_pkg::LEN_W){1'b0}}, key_length_q};
      default:                  prdata = '0;
    endcase
  end

  assign in_item.data_byte    = s_axis_tdata;
  assign in_item.end_of_input = s_axis_tlast;

  skm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  skm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_bytes_i (key_bytes_q),
    .key_len_i   (skm_pkg::eff_len(key_length_q)),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_eot_o   (m_axis_tuser)
  );

endmodule

// File: hdl/skm_front.sv
// ----------------------------------------------------------------------------
// skm_front
// Input side: takes stream items and queues them for the scanner.
// ----------------------------------------------------------------------------
module skm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  skm_pkg::item_t in_item_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output skm_pkg::item_t q_item_o
);

  skm_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push, pop;

  assign in_ready_o = (fill_q != 2'd2);
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// File: hdl/skm_back.sv
// ----------------------------------------------------------------------------
// skm_back
// Scanner: window of held bytes plus the new byte, one result per cycle when
// not stalled, with a pending stage so the last result of an item can be tagged.
// ----------------------------------------------------------------------------
module skm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [skm_pkg::KEY_W-1:0]     key_bytes_i,
  input  logic [skm_pkg::LEN_W-1:0]     key_len_i,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  skm_pkg::item_t                q_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o,
  output logic                          out_eot_o
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam int unsigned N = skm_pkg::MAX_KEY_LEN;

  logic [1:0]                  state_q, state_d;
  logic [7:0]                  win_q [N];
  logic [skm_pkg::CNT_W-1:0]   cnt_q;
  logic [skm_pkg::LEN_W-1:0]   star_q, star_d;
  logic                        eoi_q;
  logic                        pend_v_q;
  logic [7:0]                  pend_byte_q;
  logic                        out_v_q;
  logic [7:0]                  out_byte_q;
  logic                        out_last_q, out_eot_q;

  logic [N-1:0]                eq, len_mask, cnt_mask;
  logic                        full_hit, pre_hit, ge_len, go;
  logic                        pop, emit, shift, fin, load_out;
  logic [7:0]                  emit_byte;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      eq[i]       = (win_q[i] == key_bytes_i[8*i +: 8]);
      len_mask[i] = (skm_pkg::LEN_W'(i) < key_len_i);
      cnt_mask[i] = (skm_pkg::CNT_W'(i) < cnt_q);
    end
  end

  assign full_hit = &(eq | ~len_mask);
  assign pre_hit  = &(eq | ~cnt_mask);
  assign ge_len   = ({1'b0, cnt_q} >= {1'b0, key_len_i});
  // a step may move the pending result out
  assign go       = !pend_v_q || !out_v_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    star_d    = star_q;
    pop       = 1'b0;
    emit      = 1'b0;
    shift     = 1'b0;
    fin       = 1'b0;
    emit_byte = win_q[0];
    unique case (state_q)
      ST_LOAD: begin
        if (q_valid_i) begin
          pop     = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (go) begin
          if (star_q != '0) begin
            emit      = 1'b1;
            shift     = 1'b1;
            emit_byte = skm_pkg::STAR_CHAR;
            star_d    = star_q - 1'b1;
          end else if (cnt_q == '0) begin
            fin = 1'b1;
          end else if (ge_len && full_hit) begin
            emit      = 1'b1;
            shift     = 1'b1;
            emit_byte = skm_pkg::STAR_CHAR;
            star_d    = key_len_i - 1'b1;
          end else if (!ge_len && pre_hit) begin
            // partial match: hold the rest, or flush it at end of text
            if (eoi_q) begin
              state_d = ST_FLUSH;
            end else begin
              fin = 1'b1;
            end
          end else begin
            emit  = 1'b1;
            shift = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (go) begin
          if (cnt_q == '0) begin
            fin = 1'b1;
          end else begin
            emit  = 1'b1;
            shift = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    if (fin) begin
      state_d = ST_LOAD;
    end
  end

  assign load_out = (emit || fin) && pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      star_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      star_q  <= star_d;
      if (pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (shift) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (emit) begin
        pend_v_q <= 1'b1;
      end else if (fin) begin
        pend_v_q <= 1'b0;
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      win_q[cnt_q[skm_pkg::IDX_W-1:0]] <= q_item_i.data_byte;
      eoi_q <= q_item_i.end_of_input;
    end else if (shift) begin
      for (int i = 0; i < N - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end
    if (emit) begin
      pend_byte_q <= emit_byte;
    end
    if (load_out) begin
      out_byte_q <= pend_byte_q;
      out_last_q <= fin;
      out_eot_q  <= fin && eoi_q;
    end
  end

  assign q_ready_o   = (state_q == ST_LOAD);
  assign out_valid_o = out_v_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_eot_o   = out_eot_q;

endmodule

// File: hdl/skm_checker.sv
// ----------------------------------------------------------------------------
// skm_checker
// Port-level checks for the keyword masker, bound to the top level.
// ----------------------------------------------------------------------------
module skm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser,
  input logic       psel,
  input logic       pwrite,
  input logic [3:0] paddr,
  input logic [63:0] prdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // end of text always closes the run of its item
  a_eot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end of text without last of run");

  // nothing left over from before reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // a key length written is read back in four bits
  a_len_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && paddr == skm_pkg::ADDR_KEY_LENGTH |-> prdata[63:4] == '0)
    else $error("key length readback too wide");

endmodule

bind stream_keyword_masker_core skm_checker u_skm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .prdata        (prdata)
);
